FILE: src/ebi_pkg.sv
// shared types and constants of the encoder and button input block
`timescale 1ns / 1ps

package ebi_pkg;

  // item codes
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_ENC  = 2'd1;
  localparam logic [1:0] OP_BTN  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_RES    = 3'd0;
  localparam logic [2:0] CFG_SHORT  = 3'd1;
  localparam logic [2:0] CFG_LONG   = 3'd2;
  localparam logic [2:0] CFG_AUTO   = 3'd3;
  localparam logic [2:0] CFG_REPEAT = 3'd4;
  localparam logic [2:0] CFG_A      = 3'd5;
  localparam logic [2:0] CFG_B      = 3'd6;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration reset values
  localparam logic signed [5:0] RES_RST    = 6'sd4;
  localparam logic [14:0]       SHORT_RST  = 15'd20;
  localparam logic [14:0]       LONG_RST   = 15'd600;
  localparam logic [14:0]       AUTO_RST   = 15'd150;
  localparam logic [7:0]        REPEAT_RST = 8'h00;
  localparam logic [7:0]        A_RST      = 8'h01;
  localparam logic [7:0]        B_RST      = 8'h02;

  localparam logic signed [15:0] PRESS_MAX = 16'sh7FFF;

  // restoring divider: one quotient bit per cycle over the 8 bit count
  localparam int unsigned     DIV_STEPS = 8;
  localparam int unsigned     DIV_CNT_W = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] bus_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] encoder_steps;
    logic [7:0]        button_code;
    logic              long_flag;
  } out_item_t;

  typedef struct packed {
    logic tick;
    logic rd_btn;
    logic rd_enc_zero;
    logic div_load;
    logic div_step;
    logic div_finish;
    logic load_out;
  } ebi_cmd_t;

  typedef struct packed {
    logic res_zero;
  } ebi_status_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_FIN  = 4'b0100,
    S_PUSH = 4'b1000
  } ebi_state_e;

  // next phase code of the forward Gray sequence 00 -> 01 -> 11 -> 10 -> 00
  function automatic logic [1:0] gray_next(input logic [1:0] p);
    gray_next = {p[0], ~p[1]};
  endfunction

endpackage

FILE: src/ebi_ctrl.sv
// controller state machine: item sequencing, divider steps, output beat
`timescale 1ns / 1ps

module ebi_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          op_i,
  input  ebi_pkg::ebi_status_t status_i,
  input  logic                out_stall_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  output ebi_pkg::ebi_cmd_t   cmd_o
);

  ebi_pkg::ebi_state_e state_q, state_d;
  logic [ebi_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  logic accept;
  logic out_free;

  assign accept   = in_valid_i && (state_q == ebi_pkg::S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ebi_pkg::S_IDLE: begin
        if (accept) begin
          unique case (op_i)
            ebi_pkg::OP_TICK: cmd_o.tick = 1'b1;
            ebi_pkg::OP_BTN: begin
              cmd_o.rd_btn = 1'b1;
              state_d      = ebi_pkg::S_PUSH;
            end
            ebi_pkg::OP_ENC: begin
              if (status_i.res_zero) begin
                cmd_o.rd_enc_zero = 1'b1;
                state_d           = ebi_pkg::S_PUSH;
              end else begin
                cmd_o.div_load = 1'b1;
                cnt_d          = '0;
                state_d        = ebi_pkg::S_DIV;
              end
            end
            default: ;
          endcase
        end
      end
      ebi_pkg::S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == ebi_pkg::DIV_LAST) begin
          state_d = ebi_pkg::S_FIN;
        end
      end
      ebi_pkg::S_FIN: begin
        cmd_o.div_finish = 1'b1;
        state_d          = ebi_pkg::S_PUSH;
      end
      ebi_pkg::S_PUSH: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ebi_pkg::S_IDLE;
        end
      end
      default: state_d = ebi_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ebi_pkg::S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ebi_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: src/ebi_datapath.sv
// datapath: configuration, encoder decoding, press timing, divider, result registers
`timescale 1ns / 1ps

module ebi_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ebi_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ebi_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [7:0]                      bus_sample_i,
  input  ebi_pkg::ebi_cmd_t               cmd_i,
  output ebi_pkg::ebi_status_t            status_o,
  output ebi_pkg::out_item_t              out_data_o
);

  // configuration
  logic signed [5:0] res_q;
  logic [14:0] short_q, long_q, auto_q;
  logic [7:0]  repeat_q, a_mask_q, b_mask_q;

  // block state
  logic signed [7:0]  step_q, step_d;
  logic [1:0]         phase_q, phase_d;
  logic signed [15:0] press_q, press_d;
  logic [7:0]         prev_btn_q, prev_btn_d;
  logic [7:0]         pend_btn_q, pend_btn_d;
  logic               pend_long_q, pend_long_d;

  // divider
  logic [7:0] quot_q;
  logic [5:0] rem_q;
  logic [5:0] dmag_q;
  logic       neg_n_q, neg_d_q;

  ebi_pkg::out_item_t res_item_q;
  ebi_pkg::out_item_t out_q;

  logic [7:0]         bus;
  logic               dec_en;
  logic [1:0]         now_phase;
  logic [7:0]         btn;
  logic signed [15:0] press_inc;
  logic               hit_long;
  logic signed [16:0] upper;
  logic signed [16:0] press_x;
  logic               short_win;
  logic [6:0]         trial;
  logic               fits;
  logic [7:0]         quot_signed;
  logic [7:0]         rem_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q    <= ebi_pkg::RES_RST;
      short_q  <= ebi_pkg::SHORT_RST;
      long_q   <= ebi_pkg::LONG_RST;
      auto_q   <= ebi_pkg::AUTO_RST;
      repeat_q <= ebi_pkg::REPEAT_RST;
      a_mask_q <= ebi_pkg::A_RST;
      b_mask_q <= ebi_pkg::B_RST;
    end else if (cfg_we_i) begin
      priority case (cfg_index_i)
        ebi_pkg::CFG_RES:    res_q    <= $signed(cfg_data_i[5:0]);
        ebi_pkg::CFG_SHORT:  short_q  <= cfg_data_i[14:0];
        ebi_pkg::CFG_LONG:   long_q   <= cfg_data_i[14:0];
        ebi_pkg::CFG_AUTO:   auto_q   <= cfg_data_i[14:0];
        ebi_pkg::CFG_REPEAT: repeat_q <= cfg_data_i[7:0];
        ebi_pkg::CFG_A:      a_mask_q <= cfg_data_i[7:0];
        ebi_pkg::CFG_B:      b_mask_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign status_o.res_zero = (res_q == '0);

  // tick sample decoding
  assign bus       = ~bus_sample_i;
  assign dec_en    = !status_o.res_zero;
  assign now_phase = {|(bus & b_mask_q), |(bus & a_mask_q)};
  assign btn       = dec_en ? (bus & ~(a_mask_q | b_mask_q)) : bus;

  assign press_inc = (press_q != ebi_pkg::PRESS_MAX) ? press_q + 16'sd1 : press_q;
  assign hit_long  = (press_inc == $signed({1'b0, long_q}));
  assign upper     = $signed({2'b00, long_q}) - $signed({2'b00, auto_q});
  assign press_x   = {press_q[15], press_q};
  assign short_win = (press_x > $signed({2'b00, short_q})) && (press_x < upper);

  // restoring division step on magnitudes
  assign trial       = {rem_q, quot_q[7]};
  assign fits        = (trial >= {1'b0, dmag_q});
  assign quot_signed = (neg_n_q ^ neg_d_q) ? (8'd0 - quot_q) : quot_q;
  assign rem_ext     = {2'b00, rem_q};

  always_comb begin
    step_d      = step_q;
    phase_d     = phase_q;
    press_d     = press_q;
    prev_btn_d  = prev_btn_q;
    pend_btn_d  = pend_btn_q;
    pend_long_d = pend_long_q;
    if (cmd_i.tick) begin
      if (dec_en) begin
        if (now_phase == ebi_pkg::gray_next(phase_q)) begin
          step_d = step_q + 8'sd1;
        end else if (phase_q == ebi_pkg::gray_next(now_phase)) begin
          step_d = step_q - 8'sd1;
        end
        phase_d = now_phase;
      end
      if (btn != '0) begin
        if (btn == prev_btn_q) begin
          press_d = press_inc;
          if (hit_long) begin
            pend_btn_d  = prev_btn_q;
            pend_long_d = 1'b1;
            if ((btn & repeat_q) != '0) begin
              press_d = press_inc - $signed({1'b0, auto_q});
            end
          end
        end
      end else begin
        if (short_win) begin
          pend_btn_d = prev_btn_q;
        end
        press_d = '0;
      end
      prev_btn_d = btn;
    end
    if (cmd_i.rd_btn) begin
      pend_btn_d  = '0;
      pend_long_d = 1'b0;
    end
    if (cmd_i.rd_enc_zero) begin
      step_d = '0;
    end
    if (cmd_i.div_finish) begin
      step_d = neg_n_q ? $signed(8'd0 - rem_ext) : $signed(rem_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      phase_q     <= '0;
      press_q     <= '0;
      prev_btn_q  <= '0;
      pend_btn_q  <= '0;
      pend_long_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      phase_q     <= phase_d;
      press_q     <= press_d;
      prev_btn_q  <= prev_btn_d;
      pend_btn_q  <= pend_btn_d;
      pend_long_q <= pend_long_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      neg_n_q <= step_q[7];
      neg_d_q <= res_q[5];
      quot_q  <= step_q[7] ? (8'd0 - step_q) : step_q;
      dmag_q  <= res_q[5] ? (6'd0 - res_q) : res_q;
      rem_q   <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= fits ? 6'(trial - {1'b0, dmag_q}) : trial[5:0];
      quot_q <= {quot_q[6:0], fits};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_btn) begin
      res_item_q.encoder_steps <= '0;
      res_item_q.button_code   <= pend_btn_q;
      res_item_q.long_flag     <= pend_long_q;
    end else if (cmd_i.rd_enc_zero) begin
      res_item_q.encoder_steps <= step_q;
      res_item_q.button_code   <= '0;
      res_item_q.long_flag     <= 1'b0;
    end else if (cmd_i.div_finish) begin
      res_item_q.encoder_steps <= $signed(quot_signed);
      res_item_q.button_code   <= '0;
      res_item_q.long_flag     <= 1'b0;
    end
  end

  // output register, holds while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= res_item_q;
    end
  end

  assign out_data_o = out_q;

endmodule

FILE: src/encoder_and_button_input_core.sv
// top level of the encoder and button input block
`timescale 1ns / 1ps

// usage:
// input channel (in_valid_i / in_stall_o / in_data_i) takes one beat per item:
// a tick sample, a read of encoder steps or a read of the latched button command.
// a tick is absorbed in the cycle of acceptance and gives no result; the block
// is ready for the next beat in the following cycle.
// a button read, or an encoder read with resolution zero, shows its result on
// out_valid_o once the output register takes it, and the block is ready again then.
// an encoder read with nonzero resolution runs a restoring divider, one
// quotient bit a cycle over the 8 bit count, then a finish step and the output
// push; the input side stalls until the result is in the output register.
// results leave through an output register (out_valid_o / out_stall_i /
// out_data_o): while the receiver stalls the beat holds, and ticks are still
// taken; a further read waits in the block until the register frees.
// the configuration channel (cfg_valid_i / cfg_ready_o) is always ready; it is to be
// written only while the block is idle, which the block itself does not enforce.
// reset clears the control and block state and loads the register defaults, but not
// the divider, result and output data registers; no result is pending after reset.
module encoder_and_button_input_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  ebi_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output ebi_pkg::out_item_t              out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ebi_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ebi_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  ebi_pkg::ebi_cmd_t    cmd;
  ebi_pkg::ebi_status_t status;

  assign cfg_ready_o = 1'b1;

  ebi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .op_i        (in_data_i.op),
    .status_i    (status),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  ebi_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .bus_sample_i (in_data_i.bus_sample),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_data_o   (out_data_o)
  );

endmodule

FILE: src/ebi_checker.sv
// port checker for the encoder and button input block, bound to the top level
`timescale 1ns / 1ps

module ebi_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input ebi_pkg::in_item_t               in_data_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input ebi_pkg::out_item_t              out_data_o
);

  logic in_beat;
  assign in_beat = in_valid_i && !in_stall_o;

  // a stalled result beat stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped under stall");

  // a stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result payload changed under stall");

  // a tick is absorbed at once and leaves the input side open
  a_tick_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (in_data_i.op == ebi_pkg::OP_TICK) |=> !in_stall_o)
    else $error("input stalled after a tick");

  // any read keeps the input side busy while its result is produced
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && ((in_data_i.op == ebi_pkg::OP_ENC) || (in_data_i.op == ebi_pkg::OP_BTN))
    |=> in_stall_o)
    else $error("input open during a read");

  // a button result never carries encoder steps
  a_btn_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_data_o.button_code != '0) || out_data_o.long_flag)
    |-> (out_data_o.encoder_steps == '0))
    else $error("mixed result fields");

endmodule

bind encoder_and_button_input_core ebi_checker u_ebi_checker (.*);

FILE: tb/ebi_checker.sv
// checker for the encoder and button input block: predicts read replies and compares each beat
`timescale 1ns / 1ps

module ebi_scoreboard (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  ebi_pkg::in_item_t              in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  ebi_pkg::out_item_t             out_data_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [ebi_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ebi_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             fail_count_o,
  output int                             reads_pending_o
);
  import ebi_pkg::*;

  // configuration copy
  logic signed [5:0] res_q;
  logic [14:0]       short_thr;
  logic [14:0]       long_thr;
  logic [14:0]       auto_thr;
  logic [7:0]        repeat_mask;
  logic [7:0]        a_mask;
  logic [7:0]        b_mask;

  // block state
  logic signed [7:0] step_cnt;
  logic [1:0]        last_phase;
  int                hold_cnt;
  logic [7:0]        held_btn;
  logic [7:0]        latched_btn;
  logic              latched_long;

  out_item_t reads_due_q[$];
  int        fail_n = 0;

  task automatic note_bad(input string what, input int want, input int got);
    fail_n++;
    if (fail_n <= 10) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  task automatic take_tick(input logic [7:0] raw);
    logic [7:0] bus;
    logic [7:0] btn;
    logic [1:0] now;
    logic [3:0] trans;
    int         upper;
    bus = ~raw;
    btn = bus;
    if (res_q != 0) begin
      now   = {|(bus & b_mask), |(bus & a_mask)};
      trans = {last_phase, now};
      btn   = btn & ~(a_mask | b_mask);
      // gray order 00 -> 01 -> 11 -> 10 counts up, the reverse counts down
      case (trans)
        4'h1, 4'h7, 4'hE, 4'h8: step_cnt = step_cnt + 8'sd1;
        4'h2, 4'hB, 4'hD, 4'h4: step_cnt = step_cnt - 8'sd1;
        default: ;
      endcase
      last_phase = now;
    end
    if (btn != 8'h00) begin
      if (btn == held_btn) begin
        if (hold_cnt < int'(PRESS_MAX)) hold_cnt++;
        if (hold_cnt == int'(long_thr)) begin
          latched_btn  = held_btn;
          latched_long = 1'b1;
          if ((btn & repeat_mask) != 8'h00) hold_cnt = hold_cnt - int'(auto_thr);
        end
      end
    end else begin
      upper = int'(long_thr) - int'(auto_thr);
      if (hold_cnt > int'(short_thr) && hold_cnt < upper) latched_btn = held_btn;
      hold_cnt = 0;
    end
    held_btn = btn;
  endtask

  task automatic absorb_item(input in_item_t it);
    out_item_t reply;
    int        q;
    int        s;
    int        r;
    reply = '0;
    case (it.op)
      OP_TICK: take_tick(it.bus_sample);
      OP_ENC: begin
        s = int'(step_cnt);
        r = int'(res_q);
        if (r != 0) begin
          q = s / r;
          s = s - q * r;
        end else begin
          q = s;
          s = 0;
        end
        step_cnt            = 8'(s);
        reply.encoder_steps = 8'(q);
        reads_due_q.push_back(reply);
      end
      OP_BTN: begin
        reply.button_code = latched_btn;
        reply.long_flag   = latched_long;
        latched_btn       = 8'h00;
        latched_long      = 1'b0;
        reads_due_q.push_back(reply);
      end
      default: ;
    endcase
  endtask

  task automatic check_beat(input out_item_t got);
    out_item_t want;
    if (reads_due_q.size() == 0) begin
      fail_n++;
      if (fail_n <= 10) begin
        $display("%0t: beat with nothing awaited, steps %0d button %02h long %0b", $time,
                 $signed(got.encoder_steps), got.button_code, got.long_flag);
      end
    end else begin
      want = reads_due_q.pop_front();
      if (want.encoder_steps !== got.encoder_steps) begin
        note_bad("encoder_steps", $signed(want.encoder_steps), $signed(got.encoder_steps));
      end
      if (want.button_code !== got.button_code) begin
        note_bad("button_code", want.button_code, got.button_code);
      end
      if (want.long_flag !== got.long_flag) begin
        note_bad("long_flag", want.long_flag, got.long_flag);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q        = RES_RST;
      short_thr    = SHORT_RST;
      long_thr     = LONG_RST;
      auto_thr     = AUTO_RST;
      repeat_mask  = REPEAT_RST;
      a_mask       = A_RST;
      b_mask       = B_RST;
      step_cnt     = '0;
      last_phase   = '0;
      hold_cnt     = 0;
      held_btn     = '0;
      latched_btn  = '0;
      latched_long = 1'b0;
      reads_due_q.delete();
    end else begin
      // a reply always belongs to an earlier item, so compare before predicting
      if (out_valid_i && !out_stall_i) check_beat(out_data_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_RES:    res_q       = cfg_data_i[5:0];
          CFG_SHORT:  short_thr   = cfg_data_i[14:0];
          CFG_LONG:   long_thr    = cfg_data_i[14:0];
          CFG_AUTO:   auto_thr    = cfg_data_i[14:0];
          CFG_REPEAT: repeat_mask = cfg_data_i[7:0];
          CFG_A:      a_mask      = cfg_data_i[7:0];
          CFG_B:      b_mask      = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) absorb_item(in_data_i);
    end
    reads_pending_o = reads_due_q.size();
    fail_count_o    = fail_n;
  end

endmodule

FILE: tb/tb_top.sv
// testbench top: reset, stimulus for the encoder and button input block, and the verdict
`timescale 1ns / 1ps

module tb_top;
  import ebi_pkg::*;

  localparam int         CLK_PERIOD  = 20;
  localparam int         CYCLE_LIMIT = 1_000_000;
  localparam int         HOLD_CYCLES = 300;
  localparam int         SETTLE_GAP  = 16;
  localparam int         LONG_TICKS  = 60;
  localparam logic [1:0] OP_IGNORED  = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  in_item_t              in_data   = '0;
  logic                  in_stall;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int fail_count;
  int reads_pending;
  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_req  = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycles    = 0;
  int n_sent    = 0;

  // stimulus-side view of the configuration, used only to shape the items
  int         cur_res    = 4;
  int         cur_short  = 20;
  int         cur_long   = 600;
  int         cur_auto   = 150;
  logic [7:0] cur_repeat = 8'h00;
  logic [7:0] cur_a      = 8'h01;
  logic [7:0] cur_b      = 8'h02;
  logic [1:0] enc_ph     = 2'b00;

  encoder_and_button_input_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  ebi_scoreboard u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_data_i      (out_data),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fail_count),
    .reads_pending_o (reads_pending)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic push_item(input logic [1:0] kind, input logic [7:0] bus);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{op: kind, bus_sample: bus};
    do @(posedge clk); while (in_stall);
    if (kind != OP_IGNORED) n_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value, input int width);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    // bits above the register width carry junk that must be dropped
    cfg_data  <= CFG_DATA_W'((value & ((1 << width) - 1)) | ($urandom() << width));
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input int res_v, input int short_v, input int long_v,
                           input int auto_v, input logic [7:0] rep_v,
                           input logic [7:0] a_v, input logic [7:0] b_v);
    write_reg(CFG_RES, res_v, 6);
    write_reg(CFG_SHORT, short_v, 15);
    write_reg(CFG_LONG, long_v, 15);
    write_reg(CFG_AUTO, auto_v, 15);
    write_reg(CFG_REPEAT, rep_v, 8);
    write_reg(CFG_A, a_v, 8);
    write_reg(CFG_B, b_v, 8);
    cfg_valid  <= 1'b0;
    cur_res    = res_v;
    cur_short  = short_v;
    cur_long   = long_v;
    cur_auto   = auto_v;
    cur_repeat = rep_v;
    cur_a      = a_v;
    cur_b      = b_v;
  endtask

  task automatic set_gaps(input int idle, input int stall);
    idle_pct  = idle;
    stall_pct = stall;
  endtask

  // wait until every read reply is in, then let a divide run out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reads_pending != 0) @(posedge clk);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  function automatic logic [7:0] enc_bits(input logic [1:0] ph);
    logic [7:0] bits;
    bits = 8'h00;
    if (ph[0]) bits |= ($urandom_range(0, 7) == 0) ? (cur_a & 8'($urandom())) : cur_a;
    if (ph[1]) bits |= ($urandom_range(0, 7) == 0) ? (cur_b & 8'($urandom())) : cur_b;
    return bits;
  endfunction

  task automatic turn_knob();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: enc_ph = {enc_ph[0], ~enc_ph[1]};
      4, 5, 6:    enc_ph = {~enc_ph[0], enc_ph[1]};
      7:          ;
      8:          enc_ph = enc_ph ^ 2'b11;
      default:    enc_ph = 2'($urandom());
    endcase
  endtask

  // hold one key pattern for a length mostly around a threshold, then release
  task automatic press_episode();
    logic [7:0] avail;
    logic [7:0] rep_avail;
    logic [7:0] btn;
    int         len;
    int         k;
    avail = (cur_res != 0) ? ~(cur_a | cur_b) : 8'hFF;
    btn   = 8'h00;
    if (avail != 8'h00) begin
      do btn = 8'($urandom()) & avail; while (btn == 8'h00);
      if ($urandom_range(0, 2) != 0) btn = btn & (~btn + 8'h01);
      rep_avail = cur_repeat & avail;
      if (rep_avail != 8'h00 && $urandom_range(0, 2) == 0) begin
        btn = rep_avail & (~rep_avail + 8'h01);
      end
    end
    case ($urandom_range(0, 4))
      0:       len = cur_short + $urandom_range(0, 3);
      1:       len = cur_long - cur_auto + $urandom_range(0, 2);
      2:       len = cur_long + $urandom_range(0, 3);
      3:       len = cur_long + cur_auto + $urandom_range(0, 4);
      default: len = $urandom_range(1, 12);
    endcase
    if (len < 1) len = $urandom_range(1, 4);
    if (len > 120) len = $urandom_range(100, 120);
    for (k = 0; k < len; k++) begin
      if (cur_res != 0 && $urandom_range(0, 1) == 0) turn_knob();
      push_item(OP_TICK, ~(btn | enc_bits(enc_ph)));
      if ($urandom_range(0, 15) == 0) begin
        push_item($urandom_range(0, 1) ? OP_ENC : OP_BTN, 8'($urandom()));
      end
    end
    push_item(OP_TICK, (cur_res != 0) ? ~enc_bits(enc_ph) : 8'hFF);
    if ($urandom_range(0, 2) == 0) push_item(OP_BTN, 8'($urandom()));
  endtask

  task automatic knob_spin();
    int n;
    int k;
    n = $urandom_range(1, 24);
    for (k = 0; k < n; k++) begin
      turn_knob();
      push_item(OP_TICK, ~enc_bits(enc_ph));
    end
    push_item(OP_ENC, 8'($urandom()));
  endtask

  task automatic noise_burst();
    int n;
    int k;
    n = $urandom_range(1, 6);
    for (k = 0; k < n; k++) push_item(2'($urandom()), 8'($urandom()));
  endtask

  task automatic random_phase(input int items);
    int target;
    int pick;
    target = n_sent + items;
    while (n_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) press_episode();
      else if (pick < 85) knob_spin();
      else if (pick < 97) noise_burst();
      else settle();
    end
  endtask

  initial begin
    int k;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: empty reads, unused code, a full turn each way, bus extremes
    push_item(OP_ENC, 8'h00);
    push_item(OP_BTN, 8'hFF);
    push_item(OP_IGNORED, 8'h5A);
    push_item(OP_TICK, 8'hFF);
    push_item(OP_TICK, 8'hFE);
    push_item(OP_TICK, 8'hFC);
    push_item(OP_TICK, 8'hFD);
    push_item(OP_TICK, 8'hFF);
    push_item(OP_ENC, 8'h00);
    push_item(OP_TICK, 8'hFD);
    push_item(OP_TICK, 8'hFC);
    push_item(OP_TICK, 8'hFE);
    push_item(OP_TICK, 8'hFF);
    push_item(OP_TICK, 8'hFD);
    push_item(OP_ENC, 8'hFF);
    push_item(OP_TICK, 8'h00);
    push_item(OP_TICK, 8'h00);
    push_item(OP_TICK, 8'h00);
    push_item(OP_TICK, 8'hFF);
    push_item(OP_BTN, 8'h00);
    push_item(OP_TICK, 8'h7F);
    push_item(OP_TICK, 8'h7F);
    push_item(OP_TICK, 8'hFF);
    push_item(OP_BTN, 8'h00);
    push_item(OP_ENC, 8'h00);
    settle();

    configure(4, 2, 12, 4, 8'h0C, 8'h01, 8'h02);
    set_gaps(0, 0);
    random_phase(190);
    settle();

    configure(-3, 0, 6, 0, 8'hFF, 8'h10, 8'h80);
    set_gaps(51, 0);
    random_phase(190);
    settle();

    // autorepeat larger than the long threshold drives the press count negative;
    // the long hold-off lets reads back up until the input side stalls
    configure(16, 3, 20, 30, 8'hF0, 8'h03, 8'h0C);
    set_gaps(0, 51);
    hold_req <= hold_req + 1;
    random_phase(190);
    settle();

    configure(-16, 32767, 0, 32767, 8'h00, 8'hFF, 8'hFF);
    set_gaps(8, 8);
    random_phase(190);
    settle();

    // decoding off: phase bits count as buttons
    configure(0, 1, 8, 2, 8'h55, 8'h01, 8'h02);
    set_gaps(0, 0);
    random_phase(190);
    settle();

    // one repeating key held well past the long threshold, latching long again and again
    configure(1, 5, 32, 8, 8'h81, 8'h40, 8'h20);
    set_gaps(0, 51);
    for (k = 0; k < LONG_TICKS; k++) begin
      push_item(OP_TICK, 8'hFE);
      if (k % 16 == 15) push_item(OP_BTN, 8'h00);
    end
    push_item(OP_TICK, 8'hFF);
    push_item(OP_BTN, 8'h00);
    random_phase(150);
    settle();

    configure(-1, 0, 1, 32767, 8'hFF, 8'h80, 8'h01);
    set_gaps(51, 0);
    random_phase(190);
    settle();

    configure(2, 4, 16, 6, 8'h3C, 8'h02, 8'h01);
    set_gaps(8, 8);
    random_phase(190);
    settle();

    if (fail_count == 0 && reads_pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
